>>> rtl/dh_link_transform_top_defines.svh
// Assertion macros used by the back end of the link transform RTL.
`ifndef DH_LINK_TRANSFORM_TOP_DEFINES_SVH
`define DH_LINK_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define DHL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dhl assertion failed");

// Next-cycle implication, checked on clk_i and disabled while rst_ni is low.
`define DHL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dhl assertion failed");

`endif

>>> rtl/dhl_pkg.sv
// Package with types, constants and helper functions of the link transform.
package dhl_pkg;

  localparam int unsigned AngleBitsDef  = 16;
  localparam int unsigned LengthBitsDef = 32;
  localparam int unsigned CordicSteps   = 24;
  localparam int unsigned LenW          = 48;
  localparam int unsigned FieldLenW     = 32;
  localparam int unsigned FieldAngW     = 16;
  localparam int unsigned RotW          = 16;
  localparam int unsigned CordW         = 34;
  localparam int unsigned QueueDepth    = 2;

  localparam logic signed [CordW-1:0] CordicStart = 34'sd652032874;

  typedef struct packed {
    logic signed [LenW-1:0]  len_a;
    logic signed [LenW-1:0]  off_d;
    logic signed [CordW-1:0] z_twist;
    logic                    flip_twist;
    logic signed [CordW-1:0] z_joint;
    logic                    flip_joint;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_req_t;

  function automatic logic signed [CordW-1:0] atan_phase(input logic [4:0] k);
    logic signed [CordW-1:0] r;
    unique case (k)
      5'd0:    r = 34'sd536870912;
      5'd1:    r = 34'sd316933406;
      5'd2:    r = 34'sd167458907;
      5'd3:    r = 34'sd85004757;
      5'd4:    r = 34'sd42667331;
      5'd5:    r = 34'sd21354465;
      5'd6:    r = 34'sd10679838;
      5'd7:    r = 34'sd5340245;
      5'd8:    r = 34'sd2670163;
      5'd9:    r = 34'sd1335087;
      5'd10:   r = 34'sd667544;
      5'd11:   r = 34'sd333772;
      5'd12:   r = 34'sd166886;
      5'd13:   r = 34'sd83443;
      5'd14:   r = 34'sd41722;
      5'd15:   r = 34'sd20861;
      5'd16:   r = 34'sd10430;
      5'd17:   r = 34'sd5215;
      5'd18:   r = 34'sd2608;
      5'd19:   r = 34'sd1304;
      5'd20:   r = 34'sd652;
      5'd21:   r = 34'sd326;
      5'd22:   r = 34'sd163;
      5'd23:   r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [RotW-1:0] sat_rot(input logic signed [19:0] v);
    logic signed [RotW-1:0] r;
    if (v > 20'sd32767) begin
      r = 16'sd32767;
    end else if (v < -20'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[RotW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [RotW-1:0] rnd_single(input logic signed [31:0] v);
    logic signed [32:0] s;
    s = 33'(v) + 33'sd16384;
    return sat_rot(20'(signed'(s[32:15])));
  endfunction

  function automatic logic signed [RotW-1:0] rnd_prod(input logic signed [63:0] p);
    logic signed [64:0] s;
    s = 65'(p) + (65'sd1 <<< 44);
    return sat_rot(s[64:45]);
  endfunction

endpackage

>>> rtl/dhl_if.sv
// Handshake interfaces for link parameter beats and transform beats.
interface dhl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dhl_pkg::FieldLenW-1:0] link_length;
  logic        [dhl_pkg::FieldAngW-1:0] link_twist;
  logic signed [dhl_pkg::FieldLenW-1:0] link_offset;
  logic        [dhl_pkg::FieldAngW-1:0] joint_angle;

  modport source(output valid, link_length, link_twist, link_offset, joint_angle,
                 input ready);
  modport sink(input valid, link_length, link_twist, link_offset, joint_angle,
               output ready);
endinterface

interface dhl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dhl_pkg::RotW-1:0]      r00;
  logic signed [dhl_pkg::RotW-1:0]      r01;
  logic signed [dhl_pkg::RotW-1:0]      r10;
  logic signed [dhl_pkg::RotW-1:0]      r11;
  logic signed [dhl_pkg::RotW-1:0]      r12;
  logic signed [dhl_pkg::RotW-1:0]      r20;
  logic signed [dhl_pkg::RotW-1:0]      r21;
  logic signed [dhl_pkg::RotW-1:0]      r22;
  logic signed [dhl_pkg::FieldLenW-1:0] trans_x;
  logic signed [dhl_pkg::FieldLenW-1:0] trans_y;
  logic signed [dhl_pkg::FieldLenW-1:0] trans_z;

  modport source(output valid, r00, r01, r10, r11, r12, r20, r21, r22,
                 trans_x, trans_y, trans_z, input ready);
  modport sink(input valid, r00, r01, r10, r11, r12, r20, r21, r22,
               trans_x, trans_y, trans_z, output ready);
endinterface

>>> rtl/dhl_front.sv
// Front end: accepts link beats, folds the angles and sign-extends the lengths.
module dhl_front #(
  parameter int unsigned ANGLE_BITS  = dhl_pkg::AngleBitsDef,
  parameter int unsigned LENGTH_BITS = dhl_pkg::LengthBitsDef
) (
  dhl_in_if.sink           in_i,
  input  logic             q_ready_i,
  output dhl_pkg::q_req_t  push_o
);
  import dhl_pkg::*;

  function automatic logic signed [LenW-1:0] len_ext(input logic [FieldLenW-1:0] raw);
    logic [LenW-1:0] v;
    v = LenW'(raw);
    for (int j = 0; j < LenW; j++) begin
      if (j >= LENGTH_BITS) begin
        v[j] = v[LENGTH_BITS-1];
      end
    end
    return v;
  endfunction

  function automatic logic [CordW:0] fold(input logic [FieldAngW-1:0] ang);
    logic [31:0] ph;
    logic        flip;
    ph = 32'(ang) << (32 - ANGLE_BITS);
    flip = ph[31] ^ ph[30];
    if (flip) begin
      ph[31] = ~ph[31];
    end
    return {{2{ph[31]}}, ph, flip};
  endfunction

  logic [CordW:0] twist_f;
  logic [CordW:0] joint_f;

  assign twist_f = fold(in_i.link_twist);
  assign joint_f = fold(in_i.joint_angle);

  assign in_i.ready = q_ready_i;
  assign push_o.valid = in_i.valid && q_ready_i;
  assign push_o.item.len_a = len_ext(in_i.link_length);
  assign push_o.item.off_d = len_ext(in_i.link_offset);
  assign push_o.item.z_twist = twist_f[CordW:1];
  assign push_o.item.flip_twist = twist_f[0];
  assign push_o.item.z_joint = joint_f[CordW:1];
  assign push_o.item.flip_joint = joint_f[0];
endmodule

>>> rtl/dhl_queue.sv
// Short queue that decouples the front end from the compute pipeline.
module dhl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dhl_pkg::q_req_t  push_i,
  output logic             ready_o,
  input  logic             pop_i,
  output dhl_pkg::q_req_t  head_o
);
  import dhl_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign ready_o = (cnt_q != CntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item = mem_q[rd_q];
  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_i.valid) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i.valid) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.item;
    end
  end
endmodule

>>> rtl/dhl_back.sv
// Back end: CORDIC pipelines for both angles, products, rounding and output register.
module dhl_back #(
  parameter int unsigned LENGTH_BITS = dhl_pkg::LengthBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dhl_pkg::q_req_t  req_i,
  output logic             pop_o,
  dhl_out_if.source        out_o
);
  import dhl_pkg::*;

  `include "dh_link_transform_top_defines.svh"

  localparam int unsigned SumW = 81;
  localparam logic signed [SumW-1:0] LenMax = (81'sd1 <<< (LENGTH_BITS - 1)) - 81'sd1;
  localparam logic signed [SumW-1:0] LenMin = -LenMax - 81'sd1;

  function automatic logic [FieldLenW-1:0] mask_len(input logic signed [SumW-1:0] v);
    logic [FieldLenW-1:0] m;
    for (int j = 0; j < FieldLenW; j++) begin
      m[j] = (j < LENGTH_BITS) ? v[j] : 1'b0;
    end
    return m;
  endfunction

  logic en;

  logic signed [CordW-1:0] tx_q [1:CordicSteps];
  logic signed [CordW-1:0] ty_q [1:CordicSteps];
  logic signed [CordW-1:0] tz_q [1:CordicSteps];
  logic signed [CordW-1:0] jx_q [1:CordicSteps];
  logic signed [CordW-1:0] jy_q [1:CordicSteps];
  logic signed [CordW-1:0] jz_q [1:CordicSteps];
  logic signed [LenW-1:0]  la_q [1:CordicSteps];
  logic signed [LenW-1:0]  ld_q [1:CordicSteps];
  logic [CordicSteps:1]    ft_q, fj_q, vc_q;

  assign en = !out_o.valid || out_o.ready;
  assign pop_o = en;

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    logic signed [CordW-1:0] txi, tyi, tzi, jxi, jyi, jzi;
    logic signed [LenW-1:0]  lai, ldi;
    logic                    vi, fti, fji;

    if (k == 0) begin : g_first
      assign txi = CordicStart;
      assign tyi = '0;
      assign tzi = req_i.item.z_twist;
      assign jxi = CordicStart;
      assign jyi = '0;
      assign jzi = req_i.item.z_joint;
      assign lai = req_i.item.len_a;
      assign ldi = req_i.item.off_d;
      assign vi = req_i.valid;
      assign fti = req_i.item.flip_twist;
      assign fji = req_i.item.flip_joint;
    end else begin : g_next
      assign txi = tx_q[k];
      assign tyi = ty_q[k];
      assign tzi = tz_q[k];
      assign jxi = jx_q[k];
      assign jyi = jy_q[k];
      assign jzi = jz_q[k];
      assign lai = la_q[k];
      assign ldi = ld_q[k];
      assign vi = vc_q[k];
      assign fti = ft_q[k];
      assign fji = fj_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_q[k+1] <= 1'b0;
      end else if (en) begin
        vc_q[k+1] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!tzi[CordW-1]) begin
          tx_q[k+1] <= txi - (tyi >>> k);
          ty_q[k+1] <= tyi + (txi >>> k);
          tz_q[k+1] <= tzi - atan_phase(5'(k));
        end else begin
          tx_q[k+1] <= txi + (tyi >>> k);
          ty_q[k+1] <= tyi - (txi >>> k);
          tz_q[k+1] <= tzi + atan_phase(5'(k));
        end
        if (!jzi[CordW-1]) begin
          jx_q[k+1] <= jxi - (jyi >>> k);
          jy_q[k+1] <= jyi + (jxi >>> k);
          jz_q[k+1] <= jzi - atan_phase(5'(k));
        end else begin
          jx_q[k+1] <= jxi + (jyi >>> k);
          jy_q[k+1] <= jyi - (jxi >>> k);
          jz_q[k+1] <= jzi + atan_phase(5'(k));
        end
        la_q[k+1] <= lai;
        ld_q[k+1] <= ldi;
        ft_q[k+1] <= fti;
        fj_q[k+1] <= fji;
      end
    end
  end

  logic signed [CordW-1:0] sa_w, ca_w, st_w, ct_w;
  logic signed [31:0]      sa, ca, st, ct, nsa;
  logic signed [23:0]      dh;
  logic signed [24:0]      dl;

  assign sa_w = ft_q[CordicSteps] ? -ty_q[CordicSteps] : ty_q[CordicSteps];
  assign ca_w = ft_q[CordicSteps] ? -tx_q[CordicSteps] : tx_q[CordicSteps];
  assign st_w = fj_q[CordicSteps] ? -jy_q[CordicSteps] : jy_q[CordicSteps];
  assign ct_w = fj_q[CordicSteps] ? -jx_q[CordicSteps] : jx_q[CordicSteps];
  assign sa = sa_w[31:0];
  assign ca = ca_w[31:0];
  assign st = st_w[31:0];
  assign ct = ct_w[31:0];
  assign nsa = -sa;
  assign dh = ld_q[CordicSteps][LenW-1:24];
  assign dl = {1'b0, ld_q[CordicSteps][23:0]};

  logic               vp_q, vs_q, vt_q;
  logic signed [63:0] p10_q, p11_q, p20_q, p21_q;
  logic signed [31:0] ct_q, nst_q, nsa_q, ca_q;
  logic signed [55:0] hy_q, hz_q;
  logic signed [56:0] ly_q, lz_q;
  logic signed [LenW-1:0] ap_q, as_q;

  logic signed [RotW-1:0] s00_q, s01_q, s10_q, s11_q, s12_q, s20_q, s21_q, s22_q;
  logic signed [SumW-1:0] sy_q, sz_q;

  logic signed [SumW-1:0] ry, rz;
  logic signed [SumW-1:0] sat_y, sat_z;

  assign ry = sy_q >>> 30;
  assign rz = sz_q >>> 30;
  assign sat_y = (ry > LenMax) ? LenMax : ((ry < LenMin) ? LenMin : ry);
  assign sat_z = (rz > LenMax) ? LenMax : ((rz < LenMin) ? LenMin : rz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vs_q <= 1'b0;
      vt_q <= 1'b0;
    end else if (en) begin
      vp_q <= vc_q[CordicSteps];
      vs_q <= vp_q;
      vt_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p10_q <= 64'(st) * 64'(ca);
      p11_q <= 64'(ct) * 64'(ca);
      p20_q <= 64'(st) * 64'(sa);
      p21_q <= 64'(ct) * 64'(sa);
      ct_q <= ct;
      nst_q <= -st;
      nsa_q <= nsa;
      ca_q <= ca;
      hy_q <= 56'(nsa) * 56'(dh);
      ly_q <= 57'(nsa) * 57'(dl);
      hz_q <= 56'(ca) * 56'(dh);
      lz_q <= 57'(ca) * 57'(dl);
      ap_q <= la_q[CordicSteps];

      s00_q <= rnd_single(ct_q);
      s01_q <= rnd_single(nst_q);
      s10_q <= rnd_prod(p10_q);
      s11_q <= rnd_prod(p11_q);
      s12_q <= rnd_single(nsa_q);
      s20_q <= rnd_prod(p20_q);
      s21_q <= rnd_prod(p21_q);
      s22_q <= rnd_single(ca_q);
      sy_q <= (SumW'(hy_q) <<< 24) + SumW'(ly_q) + (81'sd1 <<< 29);
      sz_q <= (SumW'(hz_q) <<< 24) + SumW'(lz_q) + (81'sd1 <<< 29);
      as_q <= ap_q;

      out_o.r00 <= s00_q;
      out_o.r01 <= s01_q;
      out_o.r10 <= s10_q;
      out_o.r11 <= s11_q;
      out_o.r12 <= s12_q;
      out_o.r20 <= s20_q;
      out_o.r21 <= s21_q;
      out_o.r22 <= s22_q;
      out_o.trans_x <= mask_len(SumW'(as_q));
      out_o.trans_y <= mask_len(sat_y);
      out_o.trans_z <= mask_len(sat_z);
    end
  end

  assign out_o.valid = vt_q;

  `DHL_ASSERT_NXT(a_stall_holds, !en, $stable(vs_q) && $stable(vp_q))
  `DHL_ASSERT_NXT(a_advance_out, en && vs_q, vt_q)
  `DHL_ASSERT_NXT(a_bubble_moves, en && !vp_q, !vs_q)
endmodule

>>> rtl/dh_link_transform_top.sv
// Top level of the modified Denavit-Hartenberg link transform.
// One beat of link parameters gives one beat of transform terms. The block
// takes a new beat every cycle and delivers one every cycle while the sink is
// ready. A beat passes through the entry queue, the two 24-stage CORDIC
// pipelines, one stage for the products, one for rounding and one for the
// output register. Rotation terms are Q1.15 rounded to nearest and saturated
// at +1; translations are Q16.16, and trans_y and trans_z saturate at the
// signed LENGTH_BITS limits while trans_x carries the link length as given.
module dh_link_transform_top #(
  parameter int unsigned ANGLE_BITS  = dhl_pkg::AngleBitsDef,
  parameter int unsigned LENGTH_BITS = dhl_pkg::LengthBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dhl_in_if.sink    in_i,
  dhl_out_if.source out_o
);
  import dhl_pkg::*;

  q_req_t push;
  q_req_t head;
  logic   q_ready;
  logic   pop;

  dhl_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .in_i     (in_i),
    .q_ready_i(q_ready),
    .push_o   (push)
  );

  dhl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ready_o(q_ready),
    .pop_i  (pop),
    .head_o (head)
  );

  dhl_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (head),
    .pop_o (pop),
    .out_o (out_o)
  );
endmodule

>>> sim/tb_dh_link_transform_top.sv
// Self-checking testbench for the modified Denavit-Hartenberg link transform.
module tb_dh_link_transform_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] len_a;
    logic        [15:0] twist;
    logic signed [31:0] off_d;
    logic        [15:0] joint;
  } link_t;

  typedef struct {
    logic signed [15:0] rot[8];
    logic signed [31:0] tr[3];
  } xform_t;

  typedef struct {
    link_t  lnk;
    bit     typed;
    xform_t want;
  } link_row_t;

  localparam longint AtanTab[24] = '{
    536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };
  localparam string FieldNames[11] = '{"r00", "r01", "r10", "r11", "r12", "r20", "r21",
                                       "r22", "trans_x", "trans_y", "trans_z"};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dhl_in_if  in_if ();
  dhl_out_if out_if ();

  dh_link_transform_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  xform_t    pending_xforms[$];
  link_row_t dir_rows[$];
  int        err_count = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;
  int        hold_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
    logic [31:0] phase;
    bit          flip;
    longint      x, y, z, dx, dy;
    phase = {ang, 16'h0000};
    flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    if (flip) begin
      phase = phase - 32'h8000_0000;
    end
    z = longint'(signed'(phase));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  function automatic logic signed [15:0] round_rot(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic logic signed [31:0] scale_len(input longint t, input longint d);
    longint r;
    r = (t * d + (longint'(1) << 29)) >>> 30;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return 32'(r);
  endfunction

  task automatic predict_xform(input link_t l, output xform_t f);
    longint sa, ca, st, ct, d;
    sin_cos(l.twist, sa, ca);
    sin_cos(l.joint, st, ct);
    d = longint'(l.off_d);
    f.rot[0] = round_rot(ct, 15);
    f.rot[1] = round_rot(-st, 15);
    f.rot[2] = round_rot(st * ca, 45);
    f.rot[3] = round_rot(ct * ca, 45);
    f.rot[4] = round_rot(-sa, 15);
    f.rot[5] = round_rot(st * sa, 45);
    f.rot[6] = round_rot(ct * sa, 45);
    f.rot[7] = round_rot(ca, 15);
    f.tr[0] = l.len_a;
    f.tr[1] = scale_len(-sa, d);
    f.tr[2] = scale_len(ca, d);
  endtask

  // Typed rows carry their own expectation; the rest go through the predictor.
  link_row_t typed_rows[$];

  always @(posedge clk_i) begin
    link_t  l;
    xform_t f;
    if (rst_ni && in_if.valid && in_if.ready) begin
      l.len_a = in_if.link_length;
      l.twist = in_if.link_twist;
      l.off_d = in_if.link_offset;
      l.joint = in_if.joint_angle;
      if (typed_rows.size() > 0 && typed_rows[0].lnk == l) begin
        f = typed_rows.pop_front().want;
      end else begin
        predict_xform(l, f);
      end
      pending_xforms.push_back(f);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    xform_t want;
    logic signed [31:0] got[11];
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (pending_xforms.size() == 0) begin
          $display("UNEXPECTED beat at %0t", $realtime);
          err_count++;
        end else begin
          want = pending_xforms.pop_front();
          got = '{out_if.r00, out_if.r01, out_if.r10, out_if.r11, out_if.r12, out_if.r20,
                  out_if.r21, out_if.r22, out_if.trans_x, out_if.trans_y, out_if.trans_z};
          for (int i = 0; i < 11; i++) begin
            if (i < 8) begin
              if (got[i][15:0] !== want.rot[i]) begin
                report_mismatch(FieldNames[i], longint'(signed'(got[i][15:0])),
                                longint'(want.rot[i]));
              end
            end else if (got[i] !== want.tr[i-8]) begin
              report_mismatch(FieldNames[i], longint'(got[i]), longint'(want.tr[i-8]));
            end
          end
        end
      end
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_link(input link_t l);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.link_length <= l.len_a;
    in_if.link_twist <= l.twist;
    in_if.link_offset <= l.off_d;
    in_if.joint_angle <= l.joint;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic link_t rand_link();
    link_t l;
    logic [15:0] quarter;
    l.len_a = $urandom;
    l.off_d = $urandom;
    if ($urandom_range(3) == 0) l.off_d = signed'($urandom_range(131072)) - 65536;
    l.twist = $urandom;
    l.joint = $urandom;
    quarter = 16'($urandom_range(3)) << 14;
    if ($urandom_range(7) == 0) l.twist = quarter + 16'(signed'($urandom_range(4)) - 2);
    if ($urandom_range(7) == 0) l.joint = quarter + 16'(signed'($urandom_range(4)) - 2);
    return l;
  endfunction

  task automatic add_row(input logic signed [31:0] a, input logic [15:0] tw,
                         input logic signed [31:0] d, input logic [15:0] th);
    link_row_t r;
    r.lnk = '{a, tw, d, th};
    r.typed = 1'b0;
    dir_rows.push_back(r);
  endtask

  task automatic add_typed(input logic signed [31:0] a);
    link_row_t r;
    r.lnk = '{a, 16'h0000, 32'sd0, 16'h0000};
    r.typed = 1'b1;
    r.want.rot = '{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0,
                   16'sd32767};
    r.want.tr = '{a, 32'sd0, 32'sd0};
    dir_rows.push_back(r);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_xforms.size() > 0) @(posedge clk_i);
    repeat (35) @(posedge clk_i);
  endtask

  initial begin
    int idle_set[4][2];
    in_if.valid = 1'b0;
    in_if.link_length = '0;
    in_if.link_twist = '0;
    in_if.link_offset = '0;
    in_if.joint_angle = '0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_typed(32'sh7fff_ffff);
    add_typed(32'sh8000_0000);
    add_row(32'sd65536, 16'd0, 32'sh7fff_ffff, 16'd16384);
    add_row(32'sd65536, 16'd0, 32'sh8000_0000, 16'd32768);
    add_row(-32'sd65536, 16'd32768, 32'sh7fff_ffff, 16'd49152);
    add_row(32'sd0, 16'd32768, 32'sh8000_0000, 16'd65535);
    add_row(32'sd1, 16'd16384, 32'sh7fff_ffff, 16'd1);
    add_row(-32'sd1, 16'd49152, 32'sh8000_0000, 16'd8192);
    add_row(32'sd12345, 16'd16383, 32'sd65536, 16'd16385);
    add_row(32'sd0, 16'd16385, -32'sd65536, 16'd32767);
    add_row(32'sd0, 16'd32767, 32'sd65536, 16'd32769);
    add_row(32'sd0, 16'd32769, 32'sd1, 16'd49151);
    add_row(32'sd0, 16'd49151, -32'sd1, 16'd49153);
    add_row(32'sd0, 16'd49153, 32'sd100000, 16'd24576);
    add_row(32'sh5555_5555, 16'hffff, 32'shaaaa_aaaa, 16'h5555);
    add_row(32'shaaaa_aaaa, 16'h5555, 32'sh5555_5555, 16'haaaa);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) typed_rows.push_back(dir_rows[i]);
    end
    foreach (dir_rows[i]) send_link(dir_rows[i].lnk);
    drain();

    idle_set = '{'{0, 0}, '{45, 0}, '{0, 45}, '{26, 26}};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = idle_set[ph][0];
      snk_stall_pct = idle_set[ph][1];
      for (int n = 0; n < 150; n++) begin
        if (ph == 1 && n == 40) hold_cycles = 200;
        send_link(rand_link());
      end
      drain();
    end

    for (int w = 0; w < 2000 && pending_xforms.size() > 0; w++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pending_xforms.size() > 0) begin
      $display("%0d expected beats never arrived", pending_xforms.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dhl_pkg.sv
rtl/dhl_if.sv
rtl/dhl_front.sv
rtl/dhl_queue.sv
rtl/dhl_back.sv
rtl/dh_link_transform_top.sv
sim/tb_dh_link_transform_top.sv
